FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Clocked concurrent assertions, with and without a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion that is switched off while reset is high.
`define TSAG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tsag assertion failed");
// Assertion that is checked during reset too.
`define TSAG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tsag assertion failed");
`endif

FILE: src/tsag_pkg.sv
// Package for the tile source address generator.
// Field widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsag_pkg;
   localparam int IDX_W        = 48;   // flat index / offset width
   localparam int LEN_W        = 13;   // config register width
   localparam int DIM_W        = 2 * LEN_W; // output dimension length
   localparam int MAX_DIMS_DEF = 4;
endpackage
`default_nettype wire

FILE: src/tsag_if.sv
// Channel interfaces for request and response transfers.
// Depends on tsag_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tsag_req_if;
   logic                      valid;
   logic                      ready;
   logic [tsag_pkg::IDX_W-1:0] flat_index;
   modport source (output valid, output flat_index, input ready);
   modport sink   (input valid, input flat_index, output ready);
endinterface

interface tsag_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tsag_pkg::IDX_W-1:0] source_offset;
   logic                      out_of_range;
   modport source (output valid, output source_offset, output out_of_range, input ready);
   modport sink   (input valid, input source_offset, input out_of_range, output ready);
endinterface
`default_nettype wire

FILE: src/tile_source_address_generator_unit.sv
// Tile source address generator, top level.
// Depends on tsag_pkg, tsag_if and tsag_div_pipe.
//
// Usage:
//  - req_if carries one flat output index per transfer; rsp_if returns the
//    matching source element offset and an out_of_range flag, in order.
//  - csr_we/csr_index/csr_wdata write source lengths (index 0..MAX_DIMS-1)
//    and repeat counts (index MAX_DIMS..2*MAX_DIMS-1); other indexes are
//    ignored. Write only while no transfer is in flight.
//  - Throughput: one transfer per cycle while rsp_if is not stalled.
//  - Pipeline: the input register, then the bit-serial divider chain:
//    48 stages per output dimension to split the index, then 26 stages
//    for the reduction by source length, then the combine entry register,
//    one multiply-add stage per dimension and the output register.
//  - Out of range is taken from the last quotient: any index left over
//    after dividing by every output dimension means the index is past the
//    total size; a zero source length flags every index.
//  - Reset (synchronous) empties the pipeline and sets all lengths and
//    repeats to 1.
//  - A stall on rsp_if freezes the whole pipeline; req_if.ready drops in
//    the same cycle, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module tile_source_address_generator_unit #(
   parameter int MAX_DIMS = tsag_pkg::MAX_DIMS_DEF,
   parameter int CSR_IW   = $clog2(2 * MAX_DIMS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tsag_req_if.sink                       req_if,
   tsag_rsp_if.source                     rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IW-1:0]         csr_index,
   input  wire logic [tsag_pkg::LEN_W-1:0] csr_wdata
);
   import tsag_pkg::*;

   localparam int SIDE_W = MAX_DIMS * DIM_W;

   // config registers and derived output dimension lengths
   logic [LEN_W-1:0] src_len_ff [MAX_DIMS];
   logic [LEN_W-1:0] rep_ff     [MAX_DIMS];
   logic [DIM_W-1:0] dim_ff     [MAX_DIMS];
   logic [MAX_DIMS-1:0] len_zero;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_csr
      logic [LEN_W-1:0] eff_rep;
      assign eff_rep     = (rep_ff[d] == '0) ? LEN_W'(1) : rep_ff[d];
      assign len_zero[d] = (src_len_ff[d] == '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            src_len_ff[d] <= LEN_W'(1);
            rep_ff[d]     <= LEN_W'(1);
         end else if (csr_we) begin
            if (csr_index == CSR_IW'(d)) begin
               src_len_ff[d] <= csr_wdata;
            end
            if (csr_index == CSR_IW'(d + MAX_DIMS)) begin
               rep_ff[d] <= csr_wdata;
            end
         end
      end

      // registered from the config; the first divide stage sits behind the input register
      always_ff @(posedge clock) begin
         dim_ff[d] <= DIM_W'(src_len_ff[d]) * DIM_W'(eff_rep);
      end
   end

   // global stall: advance when the output slot is free or being taken
   logic en;
   logic out_valid_ff;
   assign en           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // input register
   logic             in_valid_ff;
   logic [IDX_W-1:0] in_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_if.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         in_idx_ff <= req_if.flat_index;
      end
   end

   // split chain, innermost dimension first
   logic              sv   [MAX_DIMS];
   logic [IDX_W-1:0]  quo  [MAX_DIMS];
   logic [DIM_W-1:0]  remd [MAX_DIMS];
   logic [SIDE_W-1:0] side [MAX_DIMS];

   for (genvar k = 0; k < MAX_DIMS; k++) begin : g_split
      logic              v_i;
      logic [IDX_W-1:0]  n_i;
      logic [SIDE_W-1:0] s_i;
      if (k == 0) begin : g_first
         assign v_i = in_valid_ff;
         assign n_i = in_idx_ff;
         assign s_i = '0;
      end else begin : g_next
         assign v_i = sv[k-1];
         assign n_i = quo[k-1];
         assign s_i = side[k-1] | (SIDE_W'(remd[k-1]) << ((MAX_DIMS - k) * DIM_W));
      end
      tsag_div_pipe #(.NUM_W(IDX_W), .DEN_W(DIM_W), .SIDE_W(SIDE_W)) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (v_i),
         .in_num   (n_i),
         .den      (dim_ff[MAX_DIMS-1-k]),
         .in_side  (s_i),
         .out_valid(sv[k]),
         .out_quo  (quo[k]),
         .out_rem  (remd[k]),
         .out_side (side[k])
      );
   end

   logic [SIDE_W-1:0] subs;
   logic              split_oor;
   assign subs      = side[MAX_DIMS-1] | SIDE_W'(remd[MAX_DIMS-1]);
   assign split_oor = (quo[MAX_DIMS-1] != '0) || (len_zero != '0);

   // reduce each sub-index by its source length
   logic             mv   [MAX_DIMS];
   logic             moor [MAX_DIMS];
   logic [DIM_W-1:0] mquo [MAX_DIMS];
   logic [LEN_W-1:0] mrem [MAX_DIMS];

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_mod
      tsag_div_pipe #(.NUM_W(DIM_W), .DEN_W(LEN_W), .SIDE_W(1)) u_mod (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sv[MAX_DIMS-1]),
         .in_num   (subs[d*DIM_W +: DIM_W]),
         .den      (src_len_ff[d]),
         .in_side  (split_oor),
         .out_valid(mv[d]),
         .out_quo  (mquo[d]),
         .out_rem  (mrem[d]),
         .out_side (moor[d])
      );
   end

   // row-major combine, one multiply-add per stage, outermost first
   logic             c_valid_ff [MAX_DIMS+1];
   logic             c_oor_ff   [MAX_DIMS+1];
   logic [IDX_W-1:0] c_off_ff   [MAX_DIMS+1];
   logic [LEN_W-1:0] c_rem_ff   [MAX_DIMS+1][MAX_DIMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff[0] <= 1'b0;
      end else if (en) begin
         c_valid_ff[0] <= mv[0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c_oor_ff[0] <= moor[0];
         c_off_ff[0] <= '0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            c_rem_ff[0][d] <= mrem[d];
         end
      end
   end

   for (genvar j = 0; j < MAX_DIMS; j++) begin : g_comb
      logic [IDX_W+LEN_W-1:0] prod;
      logic [IDX_W-1:0]       off_in;
      assign prod   = (IDX_W+LEN_W)'(c_off_ff[j]) * (IDX_W+LEN_W)'(src_len_ff[j]);
      assign off_in = prod[IDX_W-1:0] + IDX_W'(c_rem_ff[j][j]);

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            c_valid_ff[j+1] <= c_valid_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_oor_ff[j+1] <= c_oor_ff[j];
            c_off_ff[j+1] <= off_in;
            for (int d = 0; d < MAX_DIMS; d++) begin
               c_rem_ff[j+1][d] <= c_rem_ff[j][d];
            end
         end
      end
   end

   // output register
   logic [IDX_W-1:0] out_off_ff;
   logic             out_oor_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= c_valid_ff[MAX_DIMS];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_oor_ff <= c_oor_ff[MAX_DIMS];
         out_off_ff <= c_oor_ff[MAX_DIMS] ? '0 : c_off_ff[MAX_DIMS];
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.source_offset = out_off_ff;
   assign rsp_if.out_of_range  = out_oor_ff;
endmodule
`default_nettype wire

FILE: src/tsag_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Carries a side payload alongside; standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none
module tsag_div_pipe #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 26,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [DEN_W-1:0]       out_rem,
   output logic [SIDE_W-1:0]      out_side
);
   // entry s holds the state after stage s
   logic              v_ff    [NUM_W];
   logic [NUM_W-1:0]  n_ff    [NUM_W];
   logic [DEN_W-1:0]  r_ff    [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              v_cur;
      logic [NUM_W-1:0]  n_cur;
      logic [DEN_W-1:0]  r_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W:0]    diff;
      logic [NUM_W-1:0]  n_in;
      logic [DEN_W-1:0]  r_in;

      if (s == 0) begin : g_head
         assign v_cur    = in_valid;
         assign n_cur    = in_num;
         assign r_cur    = '0;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = v_ff[s-1];
         assign n_cur    = n_ff[s-1];
         assign r_cur    = r_ff[s-1];
         assign side_cur = side_ff[s-1];
      end

      assign trial = {r_cur, n_cur[NUM_W-1]};
      assign ge    = (trial >= {1'b0, den});
      assign diff  = trial - {1'b0, den};
      assign r_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      if (NUM_W > 1) begin : g_shift
         assign n_in = {n_cur[NUM_W-2:0], ge};
      end else begin : g_one
         assign n_in = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[s]    <= n_in;
            r_ff[s]    <= r_in;
            side_ff[s] <= side_cur;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = n_ff[NUM_W-1];
   assign out_rem   = r_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule
`default_nettype wire

FILE: src/tsag_checker.sv
// Port-level checker for the tile source address generator, with its bind.
// Depends on tsag_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tsag_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [tsag_pkg::IDX_W-1:0] rsp_offset,
   input wire logic                      rsp_oor
);
   import tsag_pkg::*;
   logic unused_req_valid;
   assign unused_req_valid = req_valid;

   `TSAG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `TSAG_ASSERT(a_oor_zero, clock, reset, (rsp_valid && rsp_oor) |-> (rsp_offset == '0))
   `TSAG_ASSERT(a_ready_follows, clock, reset, req_ready == (!rsp_valid || rsp_ready))
   `TSAG_ASSERT(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_offset) && $stable(rsp_oor)))
endmodule

bind tile_source_address_generator_unit tsag_checker u_tsag_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_offset(rsp_if.source_offset),
   .rsp_oor   (rsp_if.out_of_range)
);
`default_nettype wire
